// ===== hw/rtl/lzced_pkg.sv =====
`default_nettype none

package lzced_pkg;

  // Configuration register indexes.
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 17;

  localparam logic [CFG_INDEX_W-1:0] CFG_LINE_WIDTH     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_EDGE_THRESHOLD = 2'd2;

  // Register field widths and reset values.
  localparam int LINE_WIDTH_W   = 11;
  localparam int FRAME_HEIGHT_W = 12;
  localparam int THRESHOLD_W    = 17;

  localparam int LINE_WIDTH_RESET   = 640;
  localparam int FRAME_HEIGHT_RESET = 480;
  localparam int THRESHOLD_RESET    = 1;

  // Smallest frame the detector works on.
  localparam int MIN_DIM = 3;

  // Per-pixel control carried alongside the sample in the work stage.
  typedef struct packed {
    logic produce;    // pixel lies below row 0, so a result is due
    logic interior;   // result pixel is not on the border
    logic frame_end;  // result pixel is the last one emitted in the frame
    logic first_col;  // column 0, no left neighbour
    logic has_right;  // not the last column, right neighbour exists
  } pix_ctrl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/log_zero_crossing_edge_detector.sv =====
`default_nettype none

// Channel | Ports                                             | Request
// --------+---------------------------------------------------+------------------
// in      | in_valid, in_ready, in_sample                     | one LoG sample
// out     | out_valid, out_ready, out_edge_res, out_frame_end | one edge decision
// cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data         | one register write
//
// One sample is accepted per clock unless the output stalls; accepting it reads the
// line store, and leaving the work stage scores it and loads the result register.
// Reset (synchronous, rst_n low) clears the counters, the valid flags and the
// registers to their defaults; the line store keeps its contents. A stalled output
// holds the work stage, and the input stalls once that stage is full as well.
// Writing line_width or frame_height restarts the frame at row 0, column 0.

module log_zero_crossing_edge_detector #(
  parameter int MAX_WIDTH   = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,

  input  wire logic                                in_valid,
  output      logic                                in_ready,
  input  wire logic signed [SAMPLE_BITS-1:0]       in_sample,

  output      logic                                out_valid,
  input  wire logic                                out_ready,
  output      logic                                out_edge_res,
  output      logic                                out_frame_end,

  input  wire logic                                cfg_valid,
  output      logic                                cfg_ready,
  input  wire logic [lzced_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [lzced_pkg::CFG_DATA_W-1:0]    cfg_data
);

  import lzced_pkg::*;

  localparam int S  = SAMPLE_BITS;
  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  // Width of the score compare: the summed score or the threshold, whichever is wider.
  localparam int CW = ((S + 2) > THRESHOLD_W) ? (S + 2) : THRESHOLD_W;

  localparam int W_RESET = (LINE_WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : LINE_WIDTH_RESET;

  localparam logic [AW-1:0]             WLAST_RESET = AW'(W_RESET - 1);
  localparam logic [FRAME_HEIGHT_W-1:0] HLAST_RESET = FRAME_HEIGHT_W'(FRAME_HEIGHT_RESET - 1);

  // Score of one pair. A zero centre is replaced by its stand-in; a pair of
  // nonzero values with opposite signs scores the sum of their magnitudes.
  function automatic logic [S:0] pair_score(input logic signed [S-1:0] a,
                                            input logic signed [S-1:0] stand,
                                            input logic signed [S-1:0] b);
    logic signed [S-1:0] aa;
    logic signed [S:0]   ae;
    logic signed [S:0]   be;
    logic [S:0]          ma;
    logic [S:0]          mb;
    aa = (a == '0) ? stand : a;
    ae = {aa[S-1], aa};
    be = {b[S-1], b};
    ma = ae[S] ? unsigned'(-ae) : unsigned'(ae);
    mb = be[S] ? unsigned'(-be) : unsigned'(be);
    if (aa != '0 && b != '0 && aa[S-1] != b[S-1]) begin
      return ma + mb;
    end
    return '0;
  endfunction

  // ---------------------------------------------------------------------
  // Configuration. Widths and heights are stored as their clamped last index.
  // ---------------------------------------------------------------------
  logic [AW-1:0]             wlast_r, wlast_nxt;
  logic [FRAME_HEIGHT_W-1:0] hlast_r, hlast_nxt;
  logic [THRESHOLD_W-1:0]    thresh_r;
  logic                      cfg_fire;
  logic                      restart;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign restart   = cfg_fire && (cfg_index == CFG_LINE_WIDTH || cfg_index == CFG_FRAME_HEIGHT);

  always_comb begin
    int lw;
    int fh;
    lw = int'(cfg_data[LINE_WIDTH_W-1:0]);
    fh = int'(cfg_data[FRAME_HEIGHT_W-1:0]);
    if (lw < MIN_DIM) begin
      lw = MIN_DIM;
    end else if (lw > MAX_WIDTH) begin
      lw = MAX_WIDTH;
    end
    if (fh < MIN_DIM) begin
      fh = MIN_DIM;
    end
    wlast_nxt = AW'(lw - 1);
    hlast_nxt = FRAME_HEIGHT_W'(fh - 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlast_r  <= WLAST_RESET;
      hlast_r  <= HLAST_RESET;
      thresh_r <= THRESHOLD_W'(THRESHOLD_RESET);
    end else if (cfg_fire) begin
      unique case (cfg_index)
        CFG_LINE_WIDTH:     wlast_r  <= wlast_nxt;
        CFG_FRAME_HEIGHT:   hlast_r  <= hlast_nxt;
        CFG_EDGE_THRESHOLD: thresh_r <= cfg_data[THRESHOLD_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Raster position of the next sample.
  // ---------------------------------------------------------------------
  logic [AW-1:0]             col_r, col_nxt;
  logic [FRAME_HEIGHT_W-1:0] row_r, row_nxt;
  logic                      in_fire;
  logic                      s1_fire;
  logic [AW-1:0]             col_right;

  assign in_fire   = in_valid && in_ready;
  assign col_right = col_r + 1'b1;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (restart) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (in_fire) begin
      if (col_r == wlast_r) begin
        col_nxt = '0;
        row_nxt = (row_r == hlast_r) ? '0 : row_r + 1'b1;
      end else begin
        col_nxt = col_right;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Line store. Each entry holds the upper row (high half) and the centre
  // row (low half) of one column. Entries col and col+1 are read when the
  // sample is accepted; entry col is rewritten when the sample leaves the
  // work stage, with the old centre moving up and the new sample as centre.
  // ---------------------------------------------------------------------
  logic [2*S-1:0] line_mem [MAX_WIDTH];
  logic [2*S-1:0] rd_here_r;
  logic [S-1:0]   rd_right_r;

  logic                     s1_valid_r;
  logic signed [S-1:0]      s1_sample_r;
  logic [AW-1:0]            s1_col_r;
  pix_ctrl_t                s1_ctrl_r;
  pix_ctrl_t                ctrl_nxt;

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      line_mem[s1_col_r] <= {rd_here_r[S-1:0], s1_sample_r};
    end
    if (in_fire) begin
      rd_here_r  <= line_mem[col_r];
      rd_right_r <= line_mem[col_right][S-1:0];
    end
  end

  // ---------------------------------------------------------------------
  // Work stage: sample, its position flags and the store read data.
  // ---------------------------------------------------------------------
  logic                out_valid_r;
  logic                out_edge_r;
  logic                out_fend_r;

  assign s1_fire  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_fire;

  always_comb begin
    ctrl_nxt.produce   = (row_r != '0);
    ctrl_nxt.interior  = (row_r > FRAME_HEIGHT_W'(1)) && (col_r != '0) && (col_r != wlast_r);
    ctrl_nxt.frame_end = (row_r == hlast_r) && (col_r == wlast_r);
    ctrl_nxt.first_col = (col_r == '0);
    ctrl_nxt.has_right = (col_r != wlast_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_sample_r <= in_sample;
      s1_col_r    <= col_r;
      s1_ctrl_r   <= ctrl_nxt;
    end
  end

  // The left neighbour is the centre of the previous pixel in the row.
  logic signed [S-1:0] left_r;
  logic signed [S-1:0] centre;
  logic signed [S-1:0] upper;
  logic signed [S-1:0] left;
  logic signed [S-1:0] right;
  logic [S:0]          score_h;
  logic [S:0]          score_v;
  logic [S+1:0]        score;
  logic                edge_hit;

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      left_r <= centre;
    end
  end

  always_comb begin
    centre   = signed'(rd_here_r[S-1:0]);
    upper    = signed'(rd_here_r[2*S-1:S]);
    left     = s1_ctrl_r.first_col ? '0 : left_r;
    right    = s1_ctrl_r.has_right ? signed'(rd_right_r) : '0;
    score_h  = pair_score(centre, left, right);
    score_v  = pair_score(centre, upper, s1_sample_r);
    score    = {1'b0, score_h} + {1'b0, score_v};
    edge_hit = s1_ctrl_r.interior && (CW'(score) > CW'(thresh_r));
  end

  // ---------------------------------------------------------------------
  // Result register.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && s1_ctrl_r.produce) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_ctrl_r.produce) begin
      out_edge_r <= edge_hit;
      out_fend_r <= s1_ctrl_r.frame_end;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_edge_res  = out_edge_r;
  assign out_frame_end = out_fend_r;

  // ---------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------
  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= wlast_r)
    else $error("column counter ran past the last column");

  a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    row_r <= hlast_r)
    else $error("row counter ran past the last row");

  a_frame_end_border: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_fend_r) |-> !out_edge_r)
    else $error("frame end pixel is on the border but marked as edge");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_ctrl_r.produce) |=> out_valid_r)
    else $error("produced pixel did not reach the result register");

  a_stall_holds_stage: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_ready) |=> (s1_valid_r && $stable(s1_col_r)))
    else $error("work stage moved while the output was stalled");

endmodule

`default_nettype wire
